// File: hw/rtl/sha1sh_pkg.sv
// shared types and constants for the sha-1 stream hasher
`timescale 1ns / 1ps
`default_nettype none
package sha1sh_pkg;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [4:0] DIGEST_LEN = 5'd20;
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/sha1sh_cmd_fifo.sv
// small command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module sha1sh_cmd_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire sha1sh_pkg::cmd_t wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output sha1sh_pkg::cmd_t      rd_data,
    output logic                  empty
);
    sha1sh_pkg::cmd_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full    = cnt_reg == 3'd4;
    assign empty   = cnt_reg == 3'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (wr_en && !full)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && !full) wp_reg <= wp_reg + 2'd1;
            if (rd_en && !empty) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr_en && !full) - 3'(rd_en && !empty);
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/sha1sh_engine.sv
// back end: block buffer, padding, round unit and digest output
`timescale 1ns / 1ps
`default_nettype none
module sha1sh_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire sha1sh_pkg::cmd_t cmd,
    output logic                  cmd_take,
    input  wire logic [4:0]       out_len,
    output logic [7:0]            digest_byte,
    output logic                  last,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  idle
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  st_reg;
    logic [7:0]  buf_mem [64];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic        fin_reg;
    logic        lenblk_reg;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [6:0]  t_reg;
    logic [5:0]  ld_reg;
    logic [7:0]  rd_reg;
    logic [4:0]  oi_reg, n_reg;

    logic        pad_wr;
    logic [7:0]  pad_byte;
    logic [31:0] wnew, f, k, tmp;
    logic [31:0] wsel;
    logic [4:0]  n_calc;

    assign cmd_take = (st_reg == S_IDLE) && cmd_valid;
    assign idle = (st_reg == S_IDLE);
    assign n_calc = (out_len == 5'd0) ? 5'd1 :
                    (out_len > sha1sh_pkg::DIGEST_LEN) ? sha1sh_pkg::DIGEST_LEN : out_len;

    always_comb begin
        pad_byte = 8'd0;
        pad_wr   = 1'b0;
        if (st_reg == S_PAD)
        begin
            pad_wr = 1'b1;
            if (lenblk_reg && fill_reg >= 6'd56)
            begin
                pad_byte = bits_reg[(6'd63 - fill_reg) * 8 +: 8];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd_take)
        begin
            buf_mem[fill_reg] <= (cmd.op == sha1sh_pkg::OP_FINISH) ? sha1sh_pkg::PAD_BYTE
                                                                   : cmd.data;
        end
        else if (pad_wr)
        begin
            buf_mem[fill_reg] <= pad_byte;
        end
        rd_reg <= buf_mem[ld_reg];
    end

    always_comb begin
        wnew = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wnew = {wnew[30:0], wnew[31]};
        wsel = (t_reg < 7'd16) ? w_reg[0] : wnew;
        if (t_reg < 7'd20)
        begin
            f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k = sha1sh_pkg::K0;
        end
        else if (t_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1sh_pkg::K1;
        end
        else if (t_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k = sha1sh_pkg::K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1sh_pkg::K3;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + wsel + k;
    end

    always_comb begin
        case (oi_reg[4:2])
            3'd0: digest_byte = h_reg[0][(5'd3 - {3'd0, oi_reg[1:0]}) * 8 +: 8];
            3'd1: digest_byte = h_reg[1][(5'd3 - {3'd0, oi_reg[1:0]}) * 8 +: 8];
            3'd2: digest_byte = h_reg[2][(5'd3 - {3'd0, oi_reg[1:0]}) * 8 +: 8];
            3'd3: digest_byte = h_reg[3][(5'd3 - {3'd0, oi_reg[1:0]}) * 8 +: 8];
            default: digest_byte = h_reg[4][(5'd3 - {3'd0, oi_reg[1:0]}) * 8 +: 8];
        endcase
    end
    assign last  = (oi_reg + 5'd1 == n_reg);
    assign empty = (st_reg != S_OUT);

    // schedule window and working variables, no reset needed
    always_ff @(posedge clk) begin
        if (st_reg == S_LOAD && (ld_reg != 6'd0 || t_reg == 7'd1))
        begin
            // window acts as one 64-byte shift register while loading
            for (int i = 0; i < 15; i++) w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            w_reg[15] <= {w_reg[15][23:0], rd_reg};
        end
        else if (st_reg == S_LOAD)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
            d_reg <= h_reg[3]; e_reg <= h_reg[4];
        end
        else if (st_reg == S_RND)
        begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wsel;
            e_reg <= d_reg; d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg; a_reg <= tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            fill_reg <= '0; bits_reg <= '0; fin_reg <= 1'b0; lenblk_reg <= 1'b0;
            t_reg <= '0; ld_reg <= '0; oi_reg <= '0; n_reg <= sha1sh_pkg::DIGEST_LEN;
            h_reg[0] <= sha1sh_pkg::H0; h_reg[1] <= sha1sh_pkg::H1;
            h_reg[2] <= sha1sh_pkg::H2; h_reg[3] <= sha1sh_pkg::H3;
            h_reg[4] <= sha1sh_pkg::H4;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        ld_reg <= '0;
                        if (cmd.op == sha1sh_pkg::OP_ABSORB)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            fin_reg <= 1'b0;
                            if (fill_reg == 6'd63) st_reg <= S_LOAD;
                        end
                        else
                        begin
                            fin_reg <= 1'b1;
                            lenblk_reg <= (fill_reg < 6'd56);
                            if (fill_reg == 6'd63) st_reg <= S_LOAD;
                            else st_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63) st_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    // one read per cycle, read data arrives in the cycle after its read
                    if (ld_reg == 6'd0 && t_reg == 7'd1)
                    begin
                        t_reg <= '0;
                        st_reg <= S_RND;
                    end
                    else
                    begin
                        ld_reg <= ld_reg + 6'd1;
                        if (ld_reg == 6'd63) t_reg <= 7'd1;
                    end
                end
                S_RND:
                begin
                    t_reg <= t_reg + 7'd1;
                    if (t_reg == 7'd79) st_reg <= S_ADD;
                end
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    t_reg <= '0;
                    if (!fin_reg) st_reg <= S_IDLE;
                    else if (!lenblk_reg)
                    begin
                        lenblk_reg <= 1'b1;
                        st_reg <= S_PAD;
                    end
                    else
                    begin
                        oi_reg <= '0;
                        n_reg <= n_calc;
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (pop)
                    begin
                        oi_reg <= oi_reg + 5'd1;
                        if (last)
                        begin
                            st_reg <= S_IDLE;
                            fin_reg <= 1'b0;
                            fill_reg <= '0; bits_reg <= '0;
                            h_reg[0] <= sha1sh_pkg::H0; h_reg[1] <= sha1sh_pkg::H1;
                            h_reg[2] <= sha1sh_pkg::H2; h_reg[3] <= sha1sh_pkg::H3;
                            h_reg[4] <= sha1sh_pkg::H4;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/sha1_stream_hasher_core.sv
// sha-1 stream hasher top level
// absorb: bytes are taken while the back end is idle; the 64th byte holds the back end
// while it reads the buffer into the schedule window, runs 80 rounds and does one add
// finish: padding sweep plus one or two compressions, then one digest byte per pop
// a four-entry command queue lets bytes arrive while a compression runs
// asynchronous active-low reset restores the initial chaining words and output length 20
`timescale 1ns / 1ps
`default_nettype none
module sha1_stream_hasher_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       operation,
    input  wire logic [7:0] data_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      digest_byte,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] output_bytes
);
    logic [4:0] len_reg;
    logic q_empty, take, eng_idle;
    sha1sh_pkg::cmd_t qin, qout;

    assign qin.op   = operation;
    assign qin.data = data_byte;
    assign cfg_ready = eng_idle && q_empty;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) len_reg <= sha1sh_pkg::DIGEST_LEN;
        else if (cfg_valid && cfg_ready) len_reg <= output_bytes;
    end

    sha1sh_cmd_fifo u_q (
        .clk, .rst_n, .wr_en(push), .wr_data(qin), .full,
        .rd_en(take), .rd_data(qout), .empty(q_empty)
    );

    sha1sh_engine u_eng (
        .clk, .rst_n, .cmd_valid(!q_empty), .cmd(qout), .cmd_take(take),
        .out_len(len_reg), .digest_byte, .last, .empty, .pop, .idle(eng_idle)
    );
endmodule
`default_nettype wire

// File: hw/rtl/sha1sh_checker.sv
// port-level checker for the hasher, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module sha1sh_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] digest_byte,
    input wire logic       last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(digest_byte))
        else $error("result changed while waiting");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && last |=> empty)
        else $error("results continue after last");
    a_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result during reset");
endmodule
bind sha1_stream_hasher_core sha1sh_checker u_chk (
    .clk, .rst_n, .empty, .pop, .digest_byte, .last
);
`default_nettype wire

// File: tb/sv/sha1_stream_hasher_core_test.sv
// self-checking testbench for the sha-1 stream hasher core
`timescale 1ns / 1ps
`default_nettype none
module sha1_stream_hasher_core_test;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic       last;
    } digest_out_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic       operation;
    logic [7:0] data_byte;
    logic       empty;
    logic       pop;
    logic [7:0] digest_byte;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] output_bytes;

    sha1_stream_hasher_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .data_byte(data_byte),
        .empty(empty), .pop(pop), .digest_byte(digest_byte), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .output_bytes(output_bytes)
    );

    // predictor state
    logic [31:0] hash_words [5];
    logic [7:0]  msg_block [64];
    int unsigned msg_fill;
    logic [63:0] msg_bits;
    logic [4:0]  digest_len_reg;

    sha1sh_pkg::cmd_t pending_cmds [$];
    digest_out_t      digest_fifo [$];
    int          failures;
    int          stall_cycles;
    bit          hold_receiver;
    int          idle_cycles;
    int          digests_seen;
    int          messages_done;
    int          items_queued;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rol32(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void run_rounds();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, wt;
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2];
        d = hash_words[3]; e = hash_words[4];
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wt = w[r];
            else
            begin
                wt = rol32(w[(r-3)&15] ^ w[(r-8)&15] ^ w[(r-14)&15] ^ w[r&15], 1);
                w[r&15] = wt;
            end
            if (r < 20)
            begin
                f = d ^ (b & (c ^ d)); k = sha1sh_pkg::K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d; k = sha1sh_pkg::K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (d & (b | c)); k = sha1sh_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d; k = sha1sh_pkg::K3;
            end
            t = rol32(a, 5) + f + e + wt + k;
            e = d; d = c; c = rol32(b, 30); b = a; a = t;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c;
        hash_words[3] += d; hash_words[4] += e;
    endfunction

    function automatic void start_message();
        hash_words[0] = sha1sh_pkg::H0; hash_words[1] = sha1sh_pkg::H1;
        hash_words[2] = sha1sh_pkg::H2; hash_words[3] = sha1sh_pkg::H3;
        hash_words[4] = sha1sh_pkg::H4;
        msg_fill = 0;
        msg_bits = '0;
    endfunction

    function automatic void predict_digest(sha1sh_pkg::cmd_t cmd);
        int n;
        digest_out_t res;
        if (cmd.op == sha1sh_pkg::OP_ABSORB)
        begin
            msg_block[msg_fill] = cmd.data;
            msg_fill = (msg_fill + 1) % 64;
            msg_bits += 64'd8;
            if (msg_fill == 0)
                run_rounds();
            return;
        end
        msg_block[msg_fill] = sha1sh_pkg::PAD_BYTE;
        msg_fill = msg_fill + 1;
        if (msg_fill > 56)
        begin
            while (msg_fill < 64)
            begin
                msg_block[msg_fill] = 8'h00;
                msg_fill = msg_fill + 1;
            end
            run_rounds();
            msg_fill = 0;
        end
        while (msg_fill < 56)
        begin
            msg_block[msg_fill] = 8'h00;
            msg_fill = msg_fill + 1;
        end
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = msg_bits[63-8*i -: 8];
        run_rounds();
        n = digest_len_reg;
        if (n == 0)
            n = 1;
        if (n > sha1sh_pkg::DIGEST_LEN)
            n = sha1sh_pkg::DIGEST_LEN;
        for (int i = 0; i < n; i++)
        begin
            res.digest_byte = hash_words[i/4][31-8*(i%4) -: 8];
            res.last = (i + 1 == n);
            digest_fifo.push_back(res);
        end
        start_message();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver
    logic push_accepted;
    always @(posedge clk)
    begin
        push_accepted <= push && !full;
    end

    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            operation <= sha1sh_pkg::OP_ABSORB;
            data_byte <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (push && push_accepted)
            begin
                if (gap_left > 0 || pending_cmds.size() == 0)
                begin
                    push <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    sha1sh_pkg::cmd_t nxt;
                    nxt = pending_cmds.pop_front();
                    operation <= nxt.op;
                    data_byte <= nxt.data;
                    push <= 1'b1;
                    gap_left <= pick_gap();
                end
            end
            else if (!push)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_cmds.size() > 0)
                begin
                    sha1sh_pkg::cmd_t nxt;
                    nxt = pending_cmds.pop_front();
                    operation <= nxt.op;
                    data_byte <= nxt.data;
                    push <= 1'b1;
                    gap_left <= pick_gap();
                end
            end
        end
    end

    // predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            sha1sh_pkg::cmd_t c;
            c.op = operation;
            c.data = data_byte;
            predict_digest(c);
        end
    end

    // receiver
    int pop_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap <= 0;
            stall_cycles <= 0;
        end
        else if (hold_receiver && stall_cycles < 600)
        begin
            pop <= 1'b0;
            stall_cycles <= stall_cycles + 1;
        end
        else if (pop_gap > 0)
        begin
            pop <= 1'b0;
            pop_gap <= pop_gap - 1;
        end
        else
        begin
            pop <= 1'b1;
            pop_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            digest_out_t want;
            digests_seen++;
            if (digest_fifo.size() == 0)
            begin
                $error("unexpected digest transaction: digest_byte %02h last %0b",
                       digest_byte, last);
                failures++;
            end
            else
            begin
                want = digest_fifo.pop_front();
                if (digest_byte !== want.digest_byte)
                begin
                    $error("digest_byte expected %02h actual %02h",
                           want.digest_byte, digest_byte);
                    failures++;
                end
                if (last !== want.last)
                begin
                    $error("last expected %0b actual %0b", want.last, last);
                    failures++;
                end
                if (want.last)
                    messages_done++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || hold_receiver)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000)
            begin
                $display("watchdog expired with %0d digest bytes outstanding",
                         digest_fifo.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic queue_msg(int len, int mode);
        sha1sh_pkg::cmd_t c;
        for (int i = 0; i < len; i++)
        begin
            c.op = sha1sh_pkg::OP_ABSORB;
            case (mode)
                0: c.data = 8'h00;
                1: c.data = 8'hFF;
                default: c.data = 8'($urandom_range(0, 255));
            endcase
            pending_cmds.push_back(c);
        end
        c.op = sha1sh_pkg::OP_FINISH;
        c.data = 8'($urandom_range(0, 255));
        pending_cmds.push_back(c);
        items_queued += len + 1;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || push || digest_fifo.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_length(logic [4:0] v);
        @(negedge clk);
        output_bytes <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        digest_len_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        output_bytes = sha1sh_pkg::DIGEST_LEN;
        hold_receiver = 1'b0;
        digest_len_reg = sha1sh_pkg::DIGEST_LEN;
        start_message();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, padding boundaries, byte extremes, finish data ignored
        queue_msg(0, 2);
        queue_msg(3, 1);
        queue_msg(5, 0);
        queue_msg(1, 2);
        wait_drained();
        queue_msg(55, 2);
        queue_msg(56, 2);
        queue_msg(64, 2);
        wait_drained();

        // length extremes: zero and above twenty
        write_length(5'd0);
        queue_msg(2, 2);
        wait_drained();
        write_length(5'd31);
        queue_msg(2, 2);
        wait_drained();
        write_length(5'd1);
        queue_msg(4, 2);
        wait_drained();

        // receiver held off while the sender keeps offering
        write_length(5'd20);
        hold_receiver = 1'b1;
        for (int i = 0; i < 4; i++)
            queue_msg($urandom_range(2, 6), 2);
        wait (stall_cycles >= 600);
        hold_receiver = 1'b0;
        wait_drained();

        // random phases
        for (int ph = 0; ph < 3; ph++)
        begin
            write_length(5'($urandom_range(0, 31)));
            for (int m = 0; m < 4; m++)
            begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130)
                                                  : $urandom_range(0, 12);
                queue_msg(len, 2);
            end
            wait_drained();
        end

        $display("covered %0d items, %0d finished messages and %0d digest bytes",
                 items_queued, messages_done, digests_seen);
        $display("including padding boundaries, two-block lengths and length extremes");
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

// File: sha1_stream_hasher_core.f
hw/rtl/sha1sh_pkg.sv
hw/rtl/sha1sh_cmd_fifo.sv
hw/rtl/sha1sh_engine.sv
hw/rtl/sha1_stream_hasher_core.sv
hw/rtl/sha1sh_checker.sv
tb/sv/sha1_stream_hasher_core_test.sv
